/* src/rhp_pkg.sv */
`default_nettype none

package rhp_pkg;

  localparam int FixedLen  = 12;
  localparam int ExtHdrLen = 4;
  localparam logic [1:0] RtpVersion = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_VER = 2'd2
  } status_e;

  // header fields as seen after the current byte has been taken in
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  first_octet;
    logic [7:0]  second_octet;
    logic [15:0] seq_reg;
    logic [31:0] stamp_reg;
    logic [31:0] source_reg;
    logic [15:0] ext_words;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] head_len;
    logic [7:0]  tail_len;
    logic [15:0] seq_num;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [6:0]  payload_type;
    logic        marker;
  } result_t;

endpackage

`default_nettype wire

/* src/rhp_in_if.sv */
`default_nettype none

interface rhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* src/rhp_out_if.sv */
`default_nettype none

interface rhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] head_len;
  logic [7:0]  tail_len;
  logic [15:0] seq_num;
  logic [31:0] time_stamp;
  logic [31:0] source_id;
  logic [6:0]  payload_type;
  logic        marker;

  modport source (output valid, status, head_len, tail_len, seq_num, time_stamp,
                  source_id, payload_type, marker, input ready);
  modport sink   (input valid, status, head_len, tail_len, seq_num, time_stamp,
                  source_id, payload_type, marker, output ready);
endinterface

`default_nettype wire

/* src/rhp_capture.sv */
`default_nettype none

module rhp_capture import rhp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       last_i,
  input  wire logic [7:0] byte_i,
  output hdr_t            view_o
);

  hdr_t       hdr_q, hdr_d;
  logic [15:0] pos;
  logic [6:0]  ext_pos;

  assign pos = hdr_q.byte_count;

  always_comb begin
    hdr_d = hdr_q;
    if (pos == 16'd0) begin
      hdr_d.first_octet = byte_i;
    end else if (pos == 16'd1) begin
      hdr_d.second_octet = byte_i;
    end else if (pos inside {[16'd2:16'd3]}) begin
      hdr_d.seq_reg = {hdr_q.seq_reg[7:0], byte_i};
    end else if (pos inside {[16'd4:16'd7]}) begin
      hdr_d.stamp_reg = {hdr_q.stamp_reg[23:0], byte_i};
    end else if (pos inside {[16'd8:16'd11]}) begin
      hdr_d.source_reg = {hdr_q.source_reg[23:0], byte_i};
    end
    // extension length sits two bytes past the CSRC list
    ext_pos = 7'(FixedLen) + {hdr_d.first_octet[3:0], 2'b00} + 7'd2;
    if (pos >= 16'(FixedLen) &&
        (pos == 16'(ext_pos) || pos == 16'(ext_pos) + 16'd1)) begin
      hdr_d.ext_words = {hdr_q.ext_words[7:0], byte_i};
    end
    if (pos != 16'hFFFF) begin
      hdr_d.byte_count = pos + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
    end else if (en_i) begin
      if (last_i) begin
        hdr_q <= '0;
      end else begin
        hdr_q <= hdr_d;
      end
    end
  end

  assign view_o = hdr_d;

endmodule

`default_nettype wire

/* src/rtp_header_parser.sv */
// Channel | Dir | Payload                                   | Per item
// pkt_i   | in  | data_byte[7:0], last_byte                 | one packet byte
// res_o   | out | status, head_len, tail_len, seq_num,      | one per packet,
//         |     | time_stamp, source_id, payload_type, marker | after final byte
//
// One byte per clock while pkt_i.ready is high. The result is registered and appears
// in the cycle after the final byte is taken; the header checks feed a single result register.
// pkt_i.ready drops only while a result is held and res_o.ready is low.
// Reset clears the byte counter and all captured header fields.

`default_nettype none

module rtp_header_parser import rhp_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  rhp_in_if.sink   pkt_i,
  rhp_out_if.source res_o
);

  logic    accept;
  hdr_t    view;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic [6:0]  head_base;
  logic [18:0] ext_end;
  logic [18:0] pkt_len;

  assign pkt_i.ready = !res_valid_q || res_o.ready;
  assign accept      = pkt_i.valid && pkt_i.ready;

  rhp_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .last_i (pkt_i.last_byte),
    .byte_i (pkt_i.data_byte),
    .view_o (view)
  );

  always_comb begin
    head_base = 7'(FixedLen) + {view.first_octet[3:0], 2'b00};
    ext_end   = 19'(head_base) + 19'(ExtHdrLen) + 19'({view.ext_words, 2'b00});
    pkt_len   = 19'(view.byte_count);

    res_d.status       = ST_OK;
    res_d.head_len     = '0;
    res_d.tail_len     = view.first_octet[5] ? pkt_i.data_byte : 8'd0;
    res_d.seq_num      = view.seq_reg;
    res_d.time_stamp   = view.stamp_reg;
    res_d.source_id    = view.source_reg;
    res_d.payload_type = view.second_octet[6:0];
    res_d.marker       = view.second_octet[7];

    if (pkt_len < 19'(FixedLen)) begin
      res_d = '0;
      res_d.status = ST_SHORT;
    end else if (pkt_len < 19'(head_base)) begin
      res_d.status = ST_SHORT;
    end else if (view.first_octet[7:6] != RtpVersion) begin
      res_d.status = ST_BAD_VER;
    end else if (!view.first_octet[4]) begin
      res_d.head_len = 16'(head_base);
    end else if (pkt_len < 19'(head_base) + 19'(ExtHdrLen)) begin
      res_d.status = ST_SHORT;
    end else if (pkt_len < ext_end) begin
      res_d.status = ST_SHORT;
    end else begin
      res_d.head_len = ext_end[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept && pkt_i.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pkt_i.last_byte) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.head_len     = res_q.head_len;
  assign res_o.tail_len     = res_q.tail_len;
  assign res_o.seq_num      = res_q.seq_num;
  assign res_o.time_stamp   = res_q.time_stamp;
  assign res_o.source_id    = res_q.source_id;
  assign res_o.payload_type = res_q.payload_type;
  assign res_o.marker       = res_q.marker;

  // a final byte always produces a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pkt_i.last_byte |=> res_o.valid)
    else $error("final byte did not produce a result");

  // failed checks never report a header length
  a_fail_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ST_OK |-> res_o.head_len == 16'd0)
    else $error("failed packet carries a header length");

  // good headers are word aligned and at least the fixed header
  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == ST_OK |->
      res_o.head_len >= 16'(FixedLen) && res_o.head_len[1:0] == 2'b00)
    else $error("bad header length on ok result");

  // a result that waits while res_o.ready is low stays valid and keeps its header length
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.head_len))
    else $error("pending result changed");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  import rhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  // Tracks the header state of the packet in flight and the results it implies.
  class rtp_hdr_scoreboard;
    logic [15:0] nbytes;
    logic [7:0]  oct0;
    logic [7:0]  oct1;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] ssrc;
    logic [15:0] ext_len;
    result_t     expected_hdrs[$];
    int unsigned errors;
    int unsigned results_checked;

    function new();
      clear_hdr();
      errors = 0;
      results_checked = 0;
    endfunction

    function void clear_hdr();
      nbytes  = '0;
      oct0    = '0;
      oct1    = '0;
      seq     = '0;
      stamp   = '0;
      ssrc    = '0;
      ext_len = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned pos;
      int unsigned csrc_end;
      int unsigned head;
      int unsigned len;
      result_t r;
      pos = nbytes;
      if (pos == 0) oct0 = b;
      else if (pos == 1) oct1 = b;
      else if (pos < 4) seq = {seq[7:0], b};
      else if (pos < 8) stamp = {stamp[23:0], b};
      else if (pos < FixedLen) ssrc = {ssrc[23:0], b};
      // extension length sits at bytes 2..3 past the CSRC list, whether X is set or not
      csrc_end = FixedLen + 4 * oct0[3:0];
      if (pos >= FixedLen && (pos == csrc_end + 2 || pos == csrc_end + 3))
        ext_len = {ext_len[7:0], b};
      if (nbytes != 16'hFFFF) nbytes = nbytes + 16'd1;
      if (!last) return;

      len = nbytes;
      r = '0;
      if (len < FixedLen) begin
        r.status = ST_SHORT;
      end else begin
        r.status       = ST_OK;
        r.tail_len     = oct0[5] ? b : 8'h00;
        r.seq_num      = seq;
        r.time_stamp   = stamp;
        r.source_id    = ssrc;
        r.payload_type = oct1[6:0];
        r.marker       = oct1[7];
        head = csrc_end;
        if (len < head) begin
          r.status = ST_SHORT;
        end else if (oct0[7:6] != RtpVersion) begin
          r.status = ST_BAD_VER;
        end else if (!oct0[4]) begin
          r.head_len = head[15:0];
        end else if (len < head + ExtHdrLen) begin
          r.status = ST_SHORT;
        end else begin
          head = head + ExtHdrLen + 4 * ext_len;
          if (len < head) r.status = ST_SHORT;
          else r.head_len = head[15:0];
        end
      end
      expected_hdrs.push_back(r);
      clear_hdr();
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      results_checked++;
      if (expected_hdrs.size() == 0) begin
        $error("result with no packet pending: status %0d", got.status);
        errors++;
        return;
      end
      exp_r = expected_hdrs.pop_front();
      compare_field("status", exp_r.status, got.status);
      compare_field("head_len", exp_r.head_len, got.head_len);
      compare_field("tail_len", exp_r.tail_len, got.tail_len);
      compare_field("seq_num", exp_r.seq_num, got.seq_num);
      compare_field("time_stamp", exp_r.time_stamp, got.time_stamp);
      compare_field("source_id", exp_r.source_id, got.source_id);
      compare_field("payload_type", exp_r.payload_type, got.payload_type);
      compare_field("marker", exp_r.marker, got.marker);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rhp_in_if  pkt();
  rhp_out_if res();

  rtp_header_parser i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt),
    .res_o (res)
  );

  rtp_hdr_scoreboard sb = new();
  logic [8:0] wire_bytes[$];  // {last, data}

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Appends one packet; total > 0 cuts or extends it to that many bytes.
  task automatic push_rtp(input logic [1:0] ver, input bit pad, input bit ext, input int cc,
                          input int ext_n, input int body, input int total, input int fill);
    int csrc_end;
    int natural_len;
    int len;
    logic [7:0]  b;
    logic [15:0] en;
    en = ext_n[15:0];
    csrc_end = FixedLen + 4 * cc;
    natural_len = csrc_end + (ext ? ExtHdrLen + 4 * ext_n : 0) + body;
    len = (total > 0) ? total : natural_len;
    for (int k = 0; k < len; k++) begin
      case (fill)
        FillRandom: b = 8'($urandom_range(0, 255));
        FillZero:   b = 8'h00;
        default:    b = 8'hFF;
      endcase
      if (k == 0) b = {ver, pad, ext, 4'(cc)};
      else if (ext && k == csrc_end + 2) b = en[15:8];
      else if (ext && k == csrc_end + 3) b = en[7:0];
      wire_bytes.push_back({k == len - 1, b});
    end
  endtask

  task automatic send_all();
    int burst_left;
    int gap;
    burst_left = 0;
    foreach (wire_bytes[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        if (gap != 0) begin
          pkt.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      pkt.valid     <= 1'b1;
      pkt.data_byte <= wire_bytes[i][7:0];
      pkt.last_byte <= wire_bytes[i][8];
      do @(posedge clk_i); while (pkt.ready !== 1'b1);
      sb.take_byte(wire_bytes[i][7:0], wire_bytes[i][8]);
      burst_left--;
      @(negedge clk_i);
    end
    pkt.valid <= 1'b0;
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int cyc;
    int mode;
    int hold_left;
    bit held;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    res.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      if (!held && sb.results_checked >= 30) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= 1'($urandom_range(0, 1));
          2:       res.ready <= (cyc % 5 != 0);
          default: res.ready <= (cyc % 16 < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      result_t got;
      got.status       = status_e'(res.status);
      got.head_len     = res.head_len;
      got.tail_len     = res.tail_len;
      got.seq_num      = res.seq_num;
      got.time_stamp   = res.time_stamp;
      got.source_id    = res.source_id;
      got.payload_type = res.payload_type;
      got.marker       = res.marker;
      sb.check_result(got);
    end
  end

  initial begin
    #60ms;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int start;
    int npk;
    int kind;
    int cc;
    int ext_n;
    int body;
    int natural_len;
    int total;
    int waited;
    logic [1:0] ver;
    bit pad;
    bit ext;

    rst_ni        <= 1'b0;
    pkt.valid     <= 1'b0;
    pkt.data_byte <= 8'h00;
    pkt.last_byte <= 1'b0;

    // directed cases
    push_rtp(RtpVersion, 0, 0, 0, 0, 0, 1, FillRandom);       // single byte
    push_rtp(RtpVersion, 1, 0, 0, 0, 0, 11, FillRandom);      // one short of fixed header
    push_rtp(RtpVersion, 0, 0, 0, 0, 0, 0, FillZero);         // minimal ok packet
    push_rtp(2'd0, 0, 0, 0, 0, 3, 0, FillRandom);             // bad versions
    push_rtp(2'd1, 1, 0, 1, 0, 0, 0, FillRandom);
    push_rtp(2'd3, 0, 1, 0, 1, 0, 0, FillRandom);
    push_rtp(RtpVersion, 0, 0, 15, 0, 0, 20, FillRandom);     // CSRC list cut off
    push_rtp(2'd0, 0, 0, 3, 0, 0, 15, FillRandom);            // short beats bad version
    push_rtp(RtpVersion, 0, 1, 1, 0, 0, 18, FillRandom);      // ext header cut off
    push_rtp(RtpVersion, 1, 1, 0, 3, 0, 27, FillRandom);      // ext data one short
    push_rtp(RtpVersion, 1, 1, 2, 2, 5, 0, FillRandom);       // ext, padding, payload
    push_rtp(RtpVersion, 1, 0, 15, 0, 4, 0, FillOnes);        // max CSRC, all-ones fields
    push_rtp(2'd3, 1, 1, 15, 16'hFFFF, 0, 80, FillOnes);      // header byte all ones

    // random packets: mostly well formed, some truncated, some noise
    start = wire_bytes.size();
    npk = 0;
    while (wire_bytes.size() - start < 850 || npk < 40) begin
      kind  = $urandom_range(0, 9);
      ver   = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : RtpVersion;
      pad   = 1'($urandom_range(0, 1));
      ext   = 1'($urandom_range(0, 1));
      cc    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      ext_n = $urandom_range(0, 3);
      body  = $urandom_range(0, 12);
      natural_len = FixedLen + 4 * cc + (ext ? ExtHdrLen + 4 * ext_n : 0) + body;
      if (kind == 0) begin
        total = $urandom_range(1, 16);
      end else if (kind == 1) begin
        total = $urandom_range(1, natural_len);
      end else if (kind == 2) begin
        // wild extension length, data missing
        ext = 1'b1;
        ext_n = $urandom_range(0, 65535);
        total = FixedLen + 4 * cc + ExtHdrLen + body;
      end else begin
        total = natural_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      end
      push_rtp(ver, pad, ext, cc, ext_n, body, total, FillRandom);
      npk++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_all();

    while (sb.expected_hdrs.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < 10) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/rhp_pkg.sv
src/rhp_in_if.sv
src/rhp_out_if.sv
src/rhp_capture.sv
src/rtp_header_parser.sv
tb/tb.sv
